>>> rtl/core/bfaq_pkg.sv
`default_nettype none

package bfaq_pkg;

    // Filter geometry.
    localparam int MAX_BITS   = 65536;
    localparam int MAX_PROBES = 32;
    localparam int POS_W      = $clog2(MAX_BITS);
    localparam int FB_W       = POS_W + 1;
    localparam int PC_W       = 6;

    // The bit store is kept as rows of WORD_W bits.
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int ROWS   = MAX_BITS / WORD_W;
    localparam int ROW_W  = POS_W - BIT_W;

    // Hash widths and constants.
    localparam int HASH_W = 32;
    localparam int DJB_W  = 64;
    localparam int CNT_W  = 32;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;
    localparam logic [DJB_W-1:0]  DJB_SEED  = 64'd5381;
    localparam logic [HASH_W-1:0] MIX_C1    = 32'h85ebca6b;
    localparam logic [HASH_W-1:0] MIX_C2    = 32'hc2b2ae35;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_BITS = 2'd0,
        REG_PROBE_COUNT = 2'd1,
        REG_CAPACITY    = 2'd2
    } cfg_reg_t;

    // Commands.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Stream payload widths.
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_BITS   = 1 + FB_W + CNT_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

>>> rtl/core/bloom_filter_add_query_unit.sv
`default_nettype none

// Bloom filter with double hashing. An element arrives as a run of byte items
// on the s_ channel, the final one marked by s_tlast; its command (add or
// query) is taken from that final item. Items are taken one per cycle while
// the unit waits for input. After the final item the element passes the hash
// finalizer, whose multiplies are each followed by a register, then waits on
// the remainder unit that reduces both hashes modulo filter_bits one bit per
// cycle, then probes the bit store (each row is read, then modified and
// written back the next cycle, with forwarding between neighboring probes)
// until the probe pipeline drains, then posts the result; only then is the
// next item accepted. A query stops probing at the first clear bit. The result
// item stays in the output register until taken, while bytes of the next
// element are accepted; a new result waits until the previous one is taken.
// After reset the bit store is cleared one 32-bit row per cycle, with no item
// accepted; configuration writes are taken at any time but must only be made
// while the block is idle.
module bloom_filter_add_query_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port.
    input  wire logic                             cfg_we,
    input  wire logic [bfaq_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [bfaq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input item channel.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bfaq_pkg::IN_DATA_W-1:0]   s_tdata,  // [7:0] data_byte
    input  wire logic [bfaq_pkg::IN_USER_W-1:0]   s_tuser,  // [0] cmd, [1] byte_valid
    input  wire logic                             s_tlast,  // last_byte
    // Result item channel.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] maybe_present, [17:1] set_bit_total, [49:18] added_total,
    // [50] over_capacity, upper bits zero
    output logic [bfaq_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import bfaq_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_HASH  = 8'b0000_0010,
        ST_MIX1  = 8'b0000_0100,
        ST_MIX2  = 8'b0000_1000,
        ST_MIX3  = 8'b0001_0000,
        ST_MODW  = 8'b0010_0000,
        ST_PROBE = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [FB_W-1:0]   filter_bits_reg;
    logic [PC_W-1:0]   probe_count_reg;
    logic [CNT_W-1:0]  capacity_reg;

    // Hash accumulators and finalizer pipeline.
    logic [HASH_W-1:0] fnv_reg;
    logic [DJB_W-1:0]  djb_reg;
    logic [HASH_W-1:0] mix_a_reg;
    logic [HASH_W-1:0] mix_b_reg;
    logic              cmd_reg;

    // Probe sequencing.
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  step_reg;
    logic [PC_W-1:0]   iss_cnt_reg;
    logic              p1_valid_reg;
    logic [ROW_W-1:0]  p1_row_reg;
    logic [BIT_W-1:0]  p1_bit_reg;
    logic              lw_valid_reg;
    logic [ROW_W-1:0]  lw_row_reg;
    logic [WORD_W-1:0] lw_data_reg;
    logic              present_reg;
    logic [ROW_W-1:0]  clr_row_reg;

    // Counters and result.
    logic [FB_W-1:0]       set_bits_reg;
    logic [CNT_W-1:0]      added_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Bit store.
    logic [WORD_W-1:0] mem [ROWS];
    logic [WORD_W-1:0] mem_q;
    logic              mem_we;
    logic [ROW_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [ROW_W-1:0]  mem_raddr;

    logic              in_accept;
    logic [FB_W-1:0]   mod_m;
    logic [PC_W-1:0]   probes;
    logic [HASH_W-1:0] fold;
    logic [HASH_W-1:0] fnv_s;
    logic [HASH_W-1:0] fold_s;
    logic [HASH_W-1:0] mix_a13;
    logic [HASH_W-1:0] mix_b13;
    logic [HASH_W-1:0] h1;
    logic [HASH_W-1:0] h2;
    logic              mod_start;
    logic              mod_done;
    logic [POS_W-1:0]  mod_rem_a;
    logic [POS_W-1:0]  mod_rem_b;
    logic [FB_W-1:0]   pos_sum;
    logic [POS_W-1:0]  pos_adv;
    logic [WORD_W-1:0] chk_word;
    logic              chk_hit;
    logic              query_miss;
    logic              issue_ok;
    logic              out_free;
    logic [CNT_W-1:0]  added_new;
    logic              over_new;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_HASH);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Out-of-range settings are clamped to the supported range.
    always_comb begin
        if (filter_bits_reg == '0) begin
            mod_m = FB_W'(1);
        end else if (filter_bits_reg > FB_W'(MAX_BITS)) begin
            mod_m = FB_W'(MAX_BITS);
        end else begin
            mod_m = filter_bits_reg;
        end
        if (probe_count_reg == '0) begin
            probes = PC_W'(1);
        end else if (probe_count_reg > PC_W'(MAX_PROBES)) begin
            probes = PC_W'(MAX_PROBES);
        end else begin
            probes = probe_count_reg;
        end
    end

    // The finalizer is split so that each multiply is followed by a register.
    always_comb begin
        fold    = djb_reg[HASH_W-1:0] ^ djb_reg[DJB_W-1:HASH_W];
        fnv_s   = fnv_reg ^ (fnv_reg >> 16);
        fold_s  = fold ^ (fold >> 16);
        mix_a13 = mix_a_reg ^ (mix_a_reg >> 13);
        mix_b13 = mix_b_reg ^ (mix_b_reg >> 13);
        h1      = mix_a_reg ^ (mix_a_reg >> 16);
        h2      = mix_b_reg ^ (mix_b_reg >> 16) | HASH_W'(1);
    end

    assign mod_start = (state_reg == ST_MIX3);

    bfaq_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .a       (h1),
        .b       (h2),
        .m       (mod_m),
        .done    (mod_done),
        .rem_a   (mod_rem_a),
        .rem_b   (mod_rem_b)
    );

    // Next probe position: both terms are below the modulus, so one
    // conditional subtract keeps the sum in range.
    always_comb begin
        pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};
        pos_adv = (pos_sum >= mod_m) ? POS_W'(pos_sum - mod_m) : POS_W'(pos_sum);
    end

    // The row read for one probe is issued while the previous probe writes its
    // row back, so the read may miss that write; the last write is forwarded.
    always_comb begin
        chk_word   = (lw_valid_reg && (lw_row_reg == p1_row_reg)) ? lw_data_reg : mem_q;
        chk_hit    = chk_word[p1_bit_reg];
        query_miss = p1_valid_reg && (cmd_reg == CMD_QUERY) && !chk_hit;
        issue_ok   = (state_reg == ST_PROBE) && (iss_cnt_reg < probes) && !query_miss;
    end

    always_comb begin
        mem_raddr = pos_reg[POS_W-1:BIT_W];
        mem_waddr = p1_row_reg;
        mem_wdata = chk_word | (WORD_W'(1) << p1_bit_reg);
        mem_we    = 1'b0;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_row_reg;
            mem_wdata = '0;
        end else if ((state_reg == ST_PROBE) && p1_valid_reg && (cmd_reg == CMD_ADD)) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    always_comb begin
        if ((cmd_reg == CMD_ADD) && (added_reg != '1)) begin
            added_new = added_reg + 1'b1;
        end else begin
            added_new = added_reg;
        end
        over_new = (capacity_reg != '0) && (added_new > capacity_reg);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            filter_bits_reg <= FB_W'(1024);
            probe_count_reg <= PC_W'(7);
            capacity_reg    <= '0;
            fnv_reg         <= FNV_BASIS;
            djb_reg         <= DJB_SEED;
            clr_row_reg     <= '0;
            iss_cnt_reg     <= '0;
            p1_valid_reg    <= 1'b0;
            lw_valid_reg    <= 1'b0;
            present_reg     <= 1'b1;
            set_bits_reg    <= '0;
            added_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_FILTER_BITS: filter_bits_reg <= cfg_wdata[FB_W-1:0];
                    REG_PROBE_COUNT: probe_count_reg <= cfg_wdata[PC_W-1:0];
                    REG_CAPACITY:    capacity_reg    <= cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            // The output register is loaded when a finished element finds it
            // free, and emptied otherwise once its item is taken.
            if ((state_reg == ST_FIN) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    lw_valid_reg <= 1'b0;
                    clr_row_reg  <= clr_row_reg + 1'b1;
                    if (clr_row_reg == ROW_W'(ROWS - 1)) begin
                        state_reg <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    if (in_accept) begin
                        if (s_tuser[1]) begin
                            fnv_reg <= (fnv_reg ^ HASH_W'(s_tdata)) * FNV_PRIME;
                            djb_reg <= (djb_reg << 5) + djb_reg + DJB_W'(s_tdata);
                        end
                        if (s_tlast) begin
                            state_reg <= ST_MIX1;
                        end
                    end
                end
                ST_MIX1: begin
                    fnv_reg   <= FNV_BASIS;
                    djb_reg   <= DJB_SEED;
                    state_reg <= ST_MIX2;
                end
                ST_MIX2: begin
                    state_reg <= ST_MIX3;
                end
                ST_MIX3: begin
                    state_reg <= ST_MODW;
                end
                ST_MODW: begin
                    if (mod_done) begin
                        iss_cnt_reg  <= '0;
                        p1_valid_reg <= 1'b0;
                        present_reg  <= 1'b1;
                        state_reg    <= ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    p1_valid_reg <= issue_ok;
                    if (issue_ok) begin
                        iss_cnt_reg <= iss_cnt_reg + 1'b1;
                    end
                    if (mem_we) begin
                        lw_valid_reg <= 1'b1;
                        if (!chk_hit) begin
                            set_bits_reg <= set_bits_reg + 1'b1;
                        end
                    end
                    if (query_miss) begin
                        present_reg <= 1'b0;
                        state_reg   <= ST_FIN;
                    end else if (!p1_valid_reg && (iss_cnt_reg == probes)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        added_reg <= added_new;
                        state_reg <= ST_HASH;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_HASH) && in_accept && s_tlast) begin
            cmd_reg <= s_tuser[0];
        end
        if (state_reg == ST_MIX1) begin
            mix_a_reg <= fnv_s * MIX_C1;
            mix_b_reg <= fold_s * MIX_C1;
        end
        if (state_reg == ST_MIX2) begin
            mix_a_reg <= mix_a13 * MIX_C2;
            mix_b_reg <= mix_b13 * MIX_C2;
        end
        if ((state_reg == ST_MODW) && mod_done) begin
            pos_reg  <= mod_rem_a;
            step_reg <= mod_rem_b;
        end else if (issue_ok) begin
            pos_reg <= pos_adv;
        end
        if (issue_ok) begin
            p1_row_reg <= pos_reg[POS_W-1:BIT_W];
            p1_bit_reg <= pos_reg[BIT_W-1:0];
        end
        if (mem_we && (state_reg == ST_PROBE)) begin
            lw_row_reg  <= mem_waddr;
            lw_data_reg <= mem_wdata;
        end
        if ((state_reg == ST_FIN) && out_free) begin
            out_data_reg <= {(OUT_DATA_W - OUT_BITS)'(0), over_new, added_new, set_bits_reg,
                             present_reg && (cmd_reg == CMD_QUERY)};
        end
    end

`ifndef ASSERT_OFF
    // Only an add may write the bit store outside the clearing pass.
    a_probe_write_is_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && (state_reg == ST_PROBE)) |-> (cmd_reg == CMD_ADD))
        else $error("bit store written during a query");

    // The remainder unit finishes only while the sequencer waits for it.
    a_mod_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == ST_MODW))
        else $error("remainder result arrived outside the wait state");

    // The set-bit count never goes down.
    a_set_bits_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |=> (set_bits_reg >= $past(set_bits_reg)))
        else $error("set-bit count decreased");

    // The item count never goes down.
    a_added_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |=> (added_reg >= $past(added_reg)))
        else $error("added item count decreased");

    // No more probes are issued than configured.
    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) |-> (iss_cnt_reg <= probes))
        else $error("probe count exceeded");
`endif

endmodule

`default_nettype wire

>>> rtl/core/bfaq_mod_unit.sv
`default_nettype none

// Two-lane restoring remainder unit: a mod m and b mod m, one dividend bit
// per cycle in each lane.
module bfaq_mod_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [bfaq_pkg::HASH_W-1:0] a,
    input  wire logic [bfaq_pkg::HASH_W-1:0] b,
    input  wire logic [bfaq_pkg::FB_W-1:0]   m,
    output logic                            done,
    output logic [bfaq_pkg::POS_W-1:0]      rem_a,
    output logic [bfaq_pkg::POS_W-1:0]      rem_b
);
    import bfaq_pkg::*;

    localparam int STEP_W = $clog2(HASH_W);

    logic              active_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [HASH_W-1:0] sha_reg;
    logic [HASH_W-1:0] shb_reg;
    logic [POS_W-1:0]  rema_reg;
    logic [POS_W-1:0]  remb_reg;
    logic [FB_W-1:0]   trial_a;
    logic [FB_W-1:0]   trial_b;
    logic [POS_W-1:0]  rema_next;
    logic [POS_W-1:0]  remb_next;

    always_comb begin
        trial_a   = {rema_reg, sha_reg[HASH_W-1]};
        trial_b   = {remb_reg, shb_reg[HASH_W-1]};
        rema_next = (trial_a >= m) ? POS_W'(trial_a - m) : POS_W'(trial_a);
        remb_next = (trial_b >= m) ? POS_W'(trial_b - m) : POS_W'(trial_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end else if (active_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(HASH_W - 1)) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sha_reg  <= a;
            shb_reg  <= b;
            rema_reg <= '0;
            remb_reg <= '0;
        end else if (active_reg) begin
            sha_reg  <= {sha_reg[HASH_W-2:0], 1'b0};
            shb_reg  <= {shb_reg[HASH_W-2:0], 1'b0};
            rema_reg <= rema_next;
            remb_reg <= remb_next;
        end
    end

    assign done  = done_reg;
    assign rem_a = rema_reg;
    assign rem_b = remb_reg;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

// Self-checking bench for the bloom filter add/query unit.
//
// An initial block builds the item stream phase by phase, with one filter
// setting per phase, and writes the setting registers while the unit is idle.
// A clocked driver feeds the items from a queue. A clocked monitor recomputes
// every element (both hashes, the mixing step and the probe walk) on its own
// copy of the bit store. It then checks each result item against the oldest
// prediction.
module testbench;
    import bfaq_pkg::*;

    localparam int STALL_LIMIT   = 20000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 100;
    localparam int REPORT_MAX    = 10;
    localparam int HISTORY_MAX   = 64;

    // The register index that the unit has no register for.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One input item as the work is described: command, byte, valid, last.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       valid;
        logic       last;
    } byte_item_t;

    // One result item as packed on m_tdata, lowest field last here.
    typedef struct packed {
        logic             over;
        logic [CNT_W-1:0] added;
        logic [FB_W-1:0]  set_total;
        logic             present;
    } filter_result_t;

    // An element of up to eight bytes, the first byte in the low bits.
    typedef struct packed {
        logic [3:0]  len;
        logic [63:0] bytes;
    } element_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] data_byte
    logic [IN_USER_W-1:0]  s_tuser = '0;   // [0] cmd, [1] byte_valid
    logic                  s_tlast = 1'b0; // last_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] maybe_present, [17:1] set_bit_total, [49:18] added_total,
    // [50] over_capacity, upper bits zero
    logic [OUT_DATA_W-1:0] m_tdata;

    bloom_filter_add_query_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Items waiting to be driven, and the results the unit still owes us.
    byte_item_t     byte_queue[$];
    filter_result_t pending_results[$];
    element_t       added_elements[$];

    int  items_pushed;
    int  items_taken;
    int  stim_count;      // pushed items other than pure idle steps
    bit  calm;            // when set, neither side inserts any wait
    bit  in_taken;        // an input item was accepted at the last rising edge
    bit  out_taken;       // a result item was accepted at the last rising edge
    int  send_gap;
    int  recv_wait;
    bit  recv_armed;
    int  idle_cycles;

    int  error_count;
    int  results_checked;
    int  adds_seen;
    int  queries_seen;
    int  query_hits;
    int  setting_count;

    // Our own copy of the filter: hash accumulators, bit store, counters and
    // the three setting registers.
    bit               filter_store[MAX_BITS];
    logic [31:0]      fnv_run;
    logic [63:0]      djb_run;
    logic [FB_W-1:0]  set_count;
    logic [CNT_W-1:0] added_cnt;
    logic [FB_W-1:0]  cfg_filter_bits;
    logic [PC_W-1:0]  cfg_probe_count;
    logic [31:0]      cfg_capacity;

    // Murmur3 32-bit finalizer.
    function automatic logic [31:0] fmix32(input logic [31:0] h);
        logic [31:0] x;
        x = h;
        x = x ^ (x >> 16);
        x = x * MIX_C1;
        x = x ^ (x >> 13);
        x = x * MIX_C2;
        x = x ^ (x >> 16);
        return x;
    endfunction

    // Fold one accepted item into the hashes. On the last item of an element,
    // walk the probes and queue the result that the unit must produce.
    task automatic hash_and_probe(input byte_item_t it);
        logic [31:0]    h1;
        logic [31:0]    h2;
        logic [31:0]    folded;
        logic [63:0]    modulus;
        logic [63:0]    probes;
        logic [63:0]    pos;
        logic           hit;
        filter_result_t r;
        int             k;
        if (it.valid) begin
            fnv_run = (fnv_run ^ {24'd0, it.data}) * FNV_PRIME;
            djb_run = (djb_run << 5) + djb_run + {56'd0, it.data};
        end
        if (!it.last)
            return;

        folded = djb_run[31:0] ^ djb_run[63:32];
        h1 = fmix32(fnv_run);
        h2 = fmix32(folded) | 32'd1;
        fnv_run = FNV_BASIS;
        djb_run = DJB_SEED;

        // Out-of-range settings are pulled back into the legal range.
        modulus = 64'(cfg_filter_bits);
        if (modulus == 0)
            modulus = 1;
        if (modulus > MAX_BITS)
            modulus = MAX_BITS;
        probes = 64'(cfg_probe_count);
        if (probes == 0)
            probes = 1;
        if (probes > MAX_PROBES)
            probes = MAX_PROBES;

        hit = 1'b1;
        for (k = 0; k < probes; k++) begin
            pos = (64'(h1) + 64'(k) * 64'(h2)) % modulus;
            if (it.cmd == CMD_ADD) begin
                if (!filter_store[pos[POS_W-1:0]]) begin
                    filter_store[pos[POS_W-1:0]] = 1'b1;
                    set_count = set_count + 1'b1;
                end
            end else if (!filter_store[pos[POS_W-1:0]]) begin
                // A query gives up at the first clear bit.
                hit = 1'b0;
                break;
            end
        end

        if (it.cmd == CMD_ADD) begin
            hit = 1'b0;
            adds_seen++;
            if (added_cnt != '1)
                added_cnt = added_cnt + 1'b1;
        end else begin
            queries_seen++;
            if (hit)
                query_hits++;
        end

        r.present   = hit;
        r.set_total = set_count;
        r.added     = added_cnt;
        r.over      = (cfg_capacity != 0) && (added_cnt > cfg_capacity);
        pending_results.push_back(r);
    endtask

    // Monitor: everything is sampled at the rising edge. Register writes and
    // accepted input items update the prediction; accepted result items are
    // compared with the oldest prediction.
    always @(posedge aclk) begin : monitor_proc
        filter_result_t want;
        filter_result_t got;
        if (!aresetn) begin
            filter_store    = '{default: 1'b0};
            fnv_run         = FNV_BASIS;
            djb_run         = DJB_SEED;
            set_count       = '0;
            added_cnt       = '0;
            cfg_filter_bits = FB_W'(1024);
            cfg_probe_count = PC_W'(7);
            cfg_capacity    = '0;
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_FILTER_BITS: cfg_filter_bits = cfg_wdata[FB_W-1:0];
                    REG_PROBE_COUNT: cfg_probe_count = cfg_wdata[PC_W-1:0];
                    REG_CAPACITY:    cfg_capacity    = cfg_wdata;
                    default: ;  // no such register, the write is dropped
                endcase
            end

            if (s_tvalid && s_tready) begin
                items_taken++;
                hash_and_probe('{cmd: s_tuser[0], data: s_tdata, valid: s_tuser[1],
                                 last: s_tlast});
            end

            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_BITS-1:0];
                results_checked++;
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("result item with no prediction waiting: %h", m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    if (got != want || m_tdata[OUT_DATA_W-1:OUT_BITS] != '0) begin
                        error_count++;
                        if (error_count <= REPORT_MAX) begin
                            $display("result %0d mismatch: expected present=%0b bits=%0d added=%0d over=%0b",
                                     results_checked, want.present, want.set_total,
                                     want.added, want.over);
                            $display("    got present=%0b bits=%0d added=%0d over=%0b pad=%0h",
                                     got.present, got.set_total, got.added, got.over,
                                     m_tdata[OUT_DATA_W-1:OUT_BITS]);
                        end
                    end
                end
            end

            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
        end
    end

    // Watchdog: the clearing pass after reset and the settle pauses are the
    // longest legal stretches without a handshake, both far below the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Driver: inputs change at the falling edge. An item stays up until the
    // monitor saw it taken, then a random gap is drawn.
    always @(negedge aclk) begin : driver_proc
        byte_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!(s_tvalid && !in_taken)) begin
            if (s_tvalid)
                send_gap = calm ? 0 : $urandom_range(0, 3);
            if (send_gap == 0 && byte_queue.size() > 0) begin
                it = byte_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.data;
                s_tuser  <= {it.valid, it.cmd};
                s_tlast  <= it.last;
            end else begin
                s_tvalid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
        end
    end

    // Receiver: once a result item shows up, wait a randomly drawn delay before
    // raising tready, and drop it again after the item is taken. In calm
    // phases tready simply stays high.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_armed = 1'b0;
            recv_wait  = 0;
        end else if (calm) begin
            m_tready <= 1'b1;
            recv_armed = 1'b0;
        end else begin
            if (out_taken)
                recv_armed = 1'b0;
            if (!recv_armed && m_tvalid) begin
                recv_wait  = $urandom_range(0, 3);
                recv_armed = 1'b1;
            end
            if (recv_armed && recv_wait == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                if (recv_armed)
                    recv_wait--;
            end
        end
    end

    task automatic push_item(input logic cmd, input logic [7:0] data, input logic valid,
                             input logic last);
        byte_queue.push_back('{cmd: cmd, data: data, valid: valid, last: last});
        items_pushed++;
        if (valid || last)
            stim_count++;
    endtask

    // Send one element. Only the command on the last item matters, so the
    // earlier items carry a random one. A noisy element gets idle steps
    // scattered between its bytes.
    task automatic push_element(input logic cmd, input element_t e, input bit noisy);
        int k;
        if (e.len == 0) begin
            push_item(cmd, 8'($urandom), 1'b0, 1'b1);
        end else begin
            for (k = 0; k < e.len; k++) begin
                if (noisy && $urandom_range(0, 3) == 0)
                    push_item(1'($urandom), 8'($urandom), 1'b0, 1'b0);
                push_item((k == e.len - 1) ? cmd : 1'($urandom), e.bytes[8*k +: 8], 1'b1,
                          k == e.len - 1);
            end
        end
    endtask

    function automatic element_t random_element();
        element_t e;
        e.len   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(7, 8))
                                               : 4'($urandom_range(0, 5));
        e.bytes = {$urandom, $urandom};
        return e;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
    endtask

    task automatic set_filter(input logic [31:0] fbits, input logic [31:0] probes,
                              input logic [31:0] cap);
        write_reg(REG_FILTER_BITS, fbits);
        write_reg(REG_PROBE_COUNT, probes);
        write_reg(REG_CAPACITY, cap);
        @(negedge aclk);
        cfg_we <= 1'b0;
        setting_count++;
        calm = ($urandom_range(0, 2) == 0);
        @(posedge aclk);
    endtask

    // Wait until every item went in and every predicted result came out, then
    // give the unit time to finish any work that produces no result.
    task automatic wait_idle();
        while (!(items_taken == items_pushed && pending_results.size() == 0))
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Mostly well-formed adds and queries; queries replay earlier adds often
    // enough to hit. Some runs of idle steps and stray bytes break things up.
    task automatic random_phase(input int count);
        int       target;
        int       pick;
        int       k;
        element_t e;
        target = stim_count + count;
        while (stim_count < target) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                e = random_element();
                push_element(CMD_ADD, e, $urandom_range(0, 3) == 0);
                added_elements.push_back(e);
                if (added_elements.size() > HISTORY_MAX)
                    void'(added_elements.pop_front());
            end else if (pick <= 6 && added_elements.size() > 0) begin
                e = added_elements[$urandom_range(0, added_elements.size() - 1)];
                push_element(CMD_QUERY, e, $urandom_range(0, 3) == 0);
            end else if (pick == 9 && added_elements.size() > 0) begin
                e = added_elements[$urandom_range(0, added_elements.size() - 1)];
                push_element(CMD_ADD, e, 1'b0);
            end else if (pick == 8) begin
                // Idle steps, then stray bytes that run into the next element.
                for (k = $urandom_range(1, 3); k > 0; k--)
                    push_item(1'($urandom), 8'($urandom), 1'b0, 1'b0);
                for (k = $urandom_range(0, 2); k > 0; k--)
                    push_item(1'($urandom), 8'($urandom), 1'b1, 1'b0);
            end else begin
                push_element(CMD_QUERY, random_element(), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin : stimulus_proc
        int       n;
        element_t e;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        calm      = 1'b0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset setting. Empty elements use the
        // untouched hash seeds, so the same empty element misses before it is
        // added and hits after.
        push_item(CMD_QUERY, 8'h00, 1'b0, 1'b1);
        push_item(CMD_ADD,   8'hff, 1'b0, 1'b1);
        push_item(CMD_QUERY, 8'h5a, 1'b0, 1'b1);
        // Bytes 00 ff with an idle step between and a query command on the
        // first byte; the element is still an add.
        push_item(CMD_QUERY, 8'h00, 1'b1, 1'b0);
        push_item(CMD_QUERY, 8'ha5, 1'b0, 1'b0);
        push_item(CMD_ADD,   8'hff, 1'b1, 1'b1);
        // The hashes restarted, so the same bytes must hit.
        push_item(CMD_ADD,   8'h00, 1'b1, 1'b0);
        push_item(CMD_QUERY, 8'hff, 1'b1, 1'b1);
        // Same bytes in the other order.
        push_item(CMD_QUERY, 8'hff, 1'b1, 1'b0);
        push_item(CMD_QUERY, 8'h00, 1'b1, 1'b1);
        push_item(CMD_ADD,   8'hff, 1'b1, 1'b1);
        push_item(CMD_ADD,   8'h00, 1'b1, 1'b1);
        push_item(CMD_QUERY, 8'h00, 1'b1, 1'b1);
        e = '{len: 4'd8, bytes: '1};
        push_element(CMD_ADD, e, 1'b0);
        push_element(CMD_QUERY, e, 1'b0);
        wait_idle();

        // Both zero settings collapse to one position and one probe; the
        // unused register index must change nothing. The capacity is set so
        // that the flag turns on during the phase.
        write_reg(REG_UNUSED, 32'hffff_ffff);
        set_filter(32'd0, 32'd0, added_cnt + 32'd4);
        random_phase(80);
        wait_idle();

        // Largest legal store and probe count, largest capacity.
        set_filter(32'd65536, 32'd32, 32'hffff_ffff);
        random_phase(120);
        wait_idle();

        // Settings above the limits are clamped; capacity one keeps the
        // over-capacity flag set.
        set_filter(32'h0001_ffff, 32'd63, 32'd1);
        random_phase(100);
        wait_idle();

        // Only the low bits of the write count: this is an 8-bit store. Bits
        // set under the wider moduli stay set and stay counted.
        set_filter(32'hfffe_0008, 32'd3, 32'd0);
        random_phase(100);
        wait_idle();

        set_filter(32'd1, 32'd1, added_cnt + 32'd2);
        random_phase(60);
        wait_idle();

        for (n = 0; n < 4; n++) begin
            set_filter(($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 65536),
                       $urandom_range(1, 32),
                       ($urandom_range(0, 2) == 0) ? 32'd0
                                                  : added_cnt + $urandom_range(0, 60));
            random_phase(150);
            wait_idle();
        end

        $display("covered %0d input items, %0d adds and %0d queries (%0d hits)",
                 items_taken, adds_seen, queries_seen, query_hits);
        $display("across %0d filter settings; %0d result items checked, %0d bits set",
                 setting_count, results_checked, set_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", error_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
